// ===== rtl/emm_pkg.sv =====
// package for the event mask matcher: sizes, codes and transfer types
`default_nettype none

package emm_pkg;

  localparam int LIST_DEPTH  = 8;
  localparam int NUM_LISTS   = 3;
  localparam int NUM_ENTRIES = NUM_LISTS * LIST_DEPTH;
  localparam int STATUS_W    = 32;
  localparam int ADDR_W      = $clog2(NUM_ENTRIES);
  localparam int IDX_W       = 3;
  localparam int LIST_W      = 2;
  localparam int LEN_W       = 4;
  localparam int OP_W        = 3;
  localparam int SEL_W       = 3;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SET   = 3'd0,
    OP_CLEAR = 3'd1,
    OP_EVAL  = 3'd2,
    OP_WRITE = 3'd3,
    OP_QUERY = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_LEN   = 2'd0,
    CFG_NORMAL_LEN = 2'd1,
    CFG_LOW_LEN    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_WAIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [STATUS_W-1:0] mask;
    logic [SEL_W-1:0]    prio_select;
    logic [LIST_W-1:0]   list_id;
    logic [IDX_W-1:0]    entry_index;
    logic                entry_relation;
    logic                entry_enable;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                fired;
    logic [LIST_W-1:0]   fired_list;
    logic [IDX_W-1:0]    fired_index;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] mask;
    logic                relation;
    logic                enable;
  } entry_t;

  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [ADDR_W-1:0] addr;
    entry_t            wdata;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/emm_entry_mem.sv =====
// match entry memory with per-entry valid bits and a registered read port
`default_nettype none

module emm_entry_mem
  import emm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mem_req_t req,
  output entry_t        rd_entry
);

  entry_t                 mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] vld_r;
  entry_t                 rd_data_r;
  logic                   rd_vld_r;

  // storage array, no reset
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rd_data_r <= mem[req.addr];
    end
  end

  // never-written entries read as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr) begin
        vld_r[req.addr] <= 1'b1;
      end
      if (req.rd) begin
        rd_vld_r <= vld_r[req.addr];
      end
    end
  end

  assign rd_entry = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// ===== rtl/event_mask_matcher.sv =====
// top level of the event mask matcher: status word, list walk and result register
`default_nettype none

// Keeps a 32-bit event status word and three prioritized lists (high, normal,
// low) of eight match entries each, held in one entry memory. An item is
// taken when start is high and busy is low. Set, clear, write-entry and query
// ops finish in the accepting cycle, their single result (fired 0, last 1)
// appears on the next cycle, and busy stays low, so such ops can follow back
// to back. Evaluate raises busy after the accepting cycle: the walk reads
// all 24 entries one per cycle through the single port of the entry memory
// (unselected lists and positions past the configured length are read but
// ignored), then a wait state drains the read and a flush state emits the
// closing result. Each matching entry produces one transfer; the report of
// a match is held back until the next match or the end of the walk so that
// the final one can carry last. With no match a single fired 0, last 1
// transfer is given. Results are presented for exactly one cycle with
// out_valid high and cannot be stalled by the receiver. The entry memory
// needs no clearing pass after reset: per-entry valid bits make unwritten
// entries read as zero. List lengths above eight act as eight; the user must
// write lengths only while idle, which the block itself does not enforce.

module event_mask_matcher
  import emm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEN_W-1:0]     cfg_wdata
);

  // fire test for one stored entry
  function automatic logic entry_fires(entry_t e, logic [STATUS_W-1:0] st);
    logic [STATUS_W-1:0] hit;
    hit = e.mask & st;
    return e.enable && (e.mask != '0) &&
           ((hit == e.mask) || (e.relation && (hit != '0)));
  endfunction

  state_t              state_r, state_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [LEN_W-1:0]    len_r [NUM_LISTS];
  logic [SEL_W-1:0]    sel_r, sel_nxt;

  // walk cursor (issue side)
  logic [LIST_W-1:0]   cur_list_r, cur_list_nxt;
  logic [IDX_W-1:0]    cur_idx_r, cur_idx_nxt;

  // tag of the entry whose read data is back this cycle
  logic                chk_act_r, chk_act_nxt;
  logic [LIST_W-1:0]   chk_list_r, chk_list_nxt;
  logic [IDX_W-1:0]    chk_idx_r, chk_idx_nxt;

  // match held back until we know whether it is the last one
  logic                pend_vld_r, pend_vld_nxt;
  logic [LIST_W-1:0]   pend_list_r, pend_list_nxt;
  logic [IDX_W-1:0]    pend_idx_r, pend_idx_nxt;

  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  mem_req_t            mem_req;
  entry_t              rd_entry;

  logic                cur_sel;
  logic [LEN_W-1:0]    cur_len;
  logic                cur_act;
  logic                cur_end;
  logic                fire;

  emm_entry_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .rd_entry (rd_entry)
  );

  // list lengths, to be written only while idle; not enforced here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        len_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HIGH_LEN:   len_r[0] <= cfg_wdata;
        CFG_NORMAL_LEN: len_r[1] <= cfg_wdata;
        CFG_LOW_LEN:    len_r[2] <= cfg_wdata;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // per-position select bit and length of the list under the cursor
  always_comb begin
    case (cur_list_r)
      2'd0: begin
        cur_sel = sel_r[0];
        cur_len = len_r[0];
      end
      2'd1: begin
        cur_sel = sel_r[1];
        cur_len = len_r[1];
      end
      2'd2: begin
        cur_sel = sel_r[2];
        cur_len = len_r[2];
      end
      default: begin
        cur_sel = 1'b0;
        cur_len = '0;
      end
    endcase
  end

  // idx below the length also covers lengths above the list depth
  assign cur_act = cur_sel && (LEN_W'(cur_idx_r) < cur_len);
  assign cur_end = (cur_list_r == LIST_W'(NUM_LISTS - 1)) &&
                   (cur_idx_r == IDX_W'(LIST_DEPTH - 1));
  assign fire    = chk_act_r && entry_fires(rd_entry, status_r);

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    sel_nxt       = sel_r;
    cur_list_nxt  = cur_list_r;
    cur_idx_nxt   = cur_idx_r;
    chk_act_nxt   = 1'b0;
    chk_list_nxt  = chk_list_r;
    chk_idx_nxt   = chk_idx_r;
    pend_vld_nxt  = pend_vld_r;
    pend_list_nxt = pend_list_r;
    pend_idx_nxt  = pend_idx_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '{status: status_r, fired: 1'b0, fired_list: '0,
                      fired_index: '0, last: 1'b1};
    mem_req       = '{wr: 1'b0, rd: 1'b0, addr: '0, wdata: '0};

    // a new match pushes out the previous one, which is then not last
    if (fire) begin
      if (pend_vld_r) begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.fired       = 1'b1;
        out_data_nxt.fired_list  = pend_list_r;
        out_data_nxt.fired_index = pend_idx_r;
        out_data_nxt.last        = 1'b0;
      end
      pend_vld_nxt  = 1'b1;
      pend_list_nxt = chk_list_r;
      pend_idx_nxt  = chk_idx_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_data.op)
            OP_SET:   status_nxt = status_r | in_data.mask;
            OP_CLEAR: status_nxt = status_r & ~in_data.mask;
            OP_WRITE: begin
              if ((int'(in_data.list_id) < NUM_LISTS) &&
                  (int'(in_data.entry_index) < LIST_DEPTH)) begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = ADDR_W'(in_data.list_id) * ADDR_W'(LIST_DEPTH) +
                                ADDR_W'(in_data.entry_index);
                mem_req.wdata = '{mask: in_data.mask,
                                  relation: in_data.entry_relation,
                                  enable: in_data.entry_enable};
              end
            end
            OP_EVAL: begin
              sel_nxt      = in_data.prio_select;
              cur_list_nxt = '0;
              cur_idx_nxt  = '0;
              pend_vld_nxt = 1'b0;
              state_nxt    = ST_WALK;
            end
            default: ;  // query and unused codes leave the state alone
          endcase
          if (in_data.op != OP_EVAL) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = status_nxt;
          end
        end
      end

      ST_WALK: begin
        mem_req.rd   = 1'b1;
        mem_req.addr = ADDR_W'(cur_list_r) * ADDR_W'(LIST_DEPTH) + ADDR_W'(cur_idx_r);
        chk_act_nxt  = cur_act;
        chk_list_nxt = cur_list_r;
        chk_idx_nxt  = cur_idx_r;
        if (cur_idx_r == IDX_W'(LIST_DEPTH - 1)) begin
          cur_idx_nxt  = '0;
          cur_list_nxt = cur_list_r + LIST_W'(1);
        end else begin
          cur_idx_nxt = cur_idx_r + IDX_W'(1);
        end
        if (cur_end) begin
          state_nxt = ST_WAIT;
        end
      end

      // last read comes back this cycle
      ST_WAIT: begin
        state_nxt = ST_FLUSH;
      end

      // closing transfer: held match with last set, or the no-match result
      ST_FLUSH: begin
        out_valid_nxt = 1'b1;
        if (pend_vld_r) begin
          out_data_nxt.fired       = 1'b1;
          out_data_nxt.fired_list  = pend_list_r;
          out_data_nxt.fired_index = pend_idx_r;
        end
        pend_vld_nxt = 1'b0;
        state_nxt    = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      status_r    <= '0;
      sel_r       <= '0;
      cur_list_r  <= '0;
      cur_idx_r   <= '0;
      chk_act_r   <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      sel_r       <= sel_nxt;
      cur_list_r  <= cur_list_nxt;
      cur_idx_r   <= cur_idx_nxt;
      chk_act_r   <= chk_act_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chk_list_r  <= chk_list_nxt;
    chk_idx_r   <= chk_idx_nxt;
    pend_list_r <= pend_list_nxt;
    pend_idx_r  <= pend_idx_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a transfer that reports no match always closes its item
  a_nofire_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.fired |-> out_data.last)
    else $error("no-match transfer without last");

  // non-evaluate ops give their single closing transfer on the next cycle
  a_short_op: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.op != OP_EVAL) |=> out_valid && out_data.last)
    else $error("missing result for short op");

  // the end of a walk always produces the closing transfer
  a_flush_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FLUSH |=> out_valid && out_data.last)
    else $error("walk ended without closing transfer");

  // a reported match belongs to a list chosen by the evaluate
  a_fired_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fired |->
      (out_data.fired_list == 2'd0 && sel_r[0]) ||
      (out_data.fired_list == 2'd1 && sel_r[1]) ||
      (out_data.fired_list == 2'd2 && sel_r[2]))
    else $error("match reported from unselected list");

endmodule

`default_nettype wire

// ===== tb/sv/event_mask_matcher_tb.sv =====
// self-checking testbench for the event mask matcher: directed and random commands
`timescale 1ns / 100ps

module event_mask_matcher_tb
  import emm_pkg::*;
();

  localparam int          SETTLE_CYCLES = 40;      // longer than an eval keeps busy high
  localparam int          CYCLE_LIMIT   = 200000;  // far above the slowest correct run
  localparam int          PHASE_ITEMS   = 48;
  localparam int          NUM_PHASES    = 6;
  localparam logic [OP_W-1:0] OP_LAST_CODE = '1;   // codes above query act as query

  // shadow of the matcher: status word, entry table and list lengths, plus the
  // reports still owed by the block in the order they must come out
  class emm_shadow;
    logic [STATUS_W-1:0] status_word;
    entry_t              entries [NUM_LISTS][LIST_DEPTH];
    logic [LEN_W-1:0]    list_len [NUM_LISTS];
    out_item_t           due_reports [$];
    int                  mismatches;

    function new();
      status_word = '0;
      mismatches  = 0;
      foreach (entries[l, i]) entries[l][i] = '0;
      foreach (list_len[l]) list_len[l] = '0;
    endfunction

    function void set_length(int unsigned idx, logic [LEN_W-1:0] len);
      if (idx < NUM_LISTS) list_len[idx] = len;
    endfunction

    function int pending();
      return due_reports.size();
    endfunction

    function bit entry_hits(entry_t e);
      if (!e.enable || e.mask == '0) return 1'b0;
      if ((e.mask & status_word) == e.mask) return 1'b1;
      return e.relation && ((e.mask & status_word) != '0);
    endfunction

    // apply one accepted command and queue the reports it causes
    function void note_command(in_item_t c);
      out_item_t r;
      int        walk_len;
      int        hits;
      hits = 0;
      case (c.op)
        OP_SET:   status_word = status_word | c.mask;
        OP_CLEAR: status_word = status_word & ~c.mask;
        OP_WRITE: begin
          if (c.list_id < NUM_LISTS && c.entry_index < LIST_DEPTH)
            entries[c.list_id][c.entry_index] = '{mask: c.mask,
                                                  relation: c.entry_relation,
                                                  enable: c.entry_enable};
        end
        OP_EVAL: begin
          for (int l = 0; l < NUM_LISTS; l++) begin
            if (!c.prio_select[l]) continue;
            walk_len = (list_len[l] > LIST_DEPTH) ? LIST_DEPTH : int'(list_len[l]);
            for (int i = 0; i < walk_len; i++) begin
              if (entry_hits(entries[l][i])) begin
                r             = '0;
                r.status      = status_word;
                r.fired       = 1'b1;
                r.fired_list  = LIST_W'(l);
                r.fired_index = IDX_W'(i);
                due_reports.push_back(r);
                hits++;
              end
            end
          end
        end
        default: ;  // query and unused codes leave the state alone
      endcase
      if (hits > 0) begin
        due_reports[due_reports.size() - 1].last = 1'b1;
      end else begin
        r        = '0;
        r.status = status_word;
        r.last   = 1'b1;
        due_reports.push_back(r);
      end
    endfunction

    function void flag(string field, logic [STATUS_W-1:0] want, logic [STATUS_W-1:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (due_reports.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      want = due_reports.pop_front();
      if (got.status !== want.status) flag("status", want.status, got.status);
      if (got.fired !== want.fired) flag("fired", STATUS_W'(want.fired), STATUS_W'(got.fired));
      if (got.fired_list !== want.fired_list)
        flag("fired_list", STATUS_W'(want.fired_list), STATUS_W'(got.fired_list));
      if (got.fired_index !== want.fired_index)
        flag("fired_index", STATUS_W'(want.fired_index), STATUS_W'(got.fired_index));
      if (got.last !== want.last) flag("last", STATUS_W'(want.last), STATUS_W'(got.last));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_data;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEN_W-1:0]     cfg_wdata;

  emm_shadow   shadow;
  int unsigned idle_pct;
  int unsigned cycles;

  event_mask_matcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung block must not hang the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("event_mask_matcher_tb failed");
      $finish;
    end
  end

  // monitors sample at the rising edge, before the block's own updates land;
  // a command transfer is start high while busy is low
  always @(posedge clk) begin
    if (rst_n && start && !busy) shadow.note_command(in_data);
  end

  // results cannot be held off, so every strobe is a completed transfer
  always @(posedge clk) begin
    if (rst_n && out_valid) shadow.check_report(out_data);
  end

  function automatic in_item_t make_cmd(logic [OP_W-1:0] op, logic [STATUS_W-1:0] mask,
                                        logic [SEL_W-1:0] sel, logic [LIST_W-1:0] lid,
                                        logic [IDX_W-1:0] idx, logic rel, logic en);
    in_item_t c;
    c.op             = op;
    c.mask           = mask;
    c.prio_select    = sel;
    c.list_id        = lid;
    c.entry_index    = idx;
    c.entry_relation = rel;
    c.entry_enable   = en;
    return c;
  endfunction

  // mostly sparse masks so the status word neither fills up nor empties out
  function automatic logic [STATUS_W-1:0] random_mask();
    logic [STATUS_W-1:0] m;
    case ($urandom_range(5))
      0:       m = '1;
      1:       m = '0;
      2:       m = STATUS_W'(1) << $urandom_range(STATUS_W - 1);
      3:       m = $urandom & $urandom & $urandom;
      4:       m = $urandom;
      default: m = STATUS_W'($urandom_range(255)) << $urandom_range(STATUS_W - 8);
    endcase
    return m;
  endfunction

  // random command: every field gets random content, the op is weighted so
  // that tables get loaded and evaluated often; a few writes hit the unused list id
  function automatic in_item_t random_command();
    in_item_t    c;
    int unsigned pick;
    pick             = $urandom_range(99);
    c.mask           = random_mask();
    c.prio_select    = SEL_W'($urandom);
    c.list_id        = ($urandom_range(9) == 0) ? LIST_W'(NUM_LISTS)
                                                : LIST_W'($urandom_range(NUM_LISTS - 1));
    c.entry_index    = IDX_W'($urandom);
    c.entry_relation = 1'($urandom);
    c.entry_enable   = ($urandom_range(4) != 0);
    if (pick < 20)      c.op = OP_SET;
    else if (pick < 33) c.op = OP_CLEAR;
    else if (pick < 63) c.op = OP_EVAL;
    else if (pick < 88) c.op = OP_WRITE;
    else if (pick < 94) c.op = OP_QUERY;
    else c.op = OP_W'($urandom_range(int'(OP_QUERY) + 1, int'(OP_LAST_CODE)));
    return c;
  endfunction

  // one command transfer; called and returns at a falling edge, leaves start
  // high so back-to-back commands keep it raised
  task automatic send_cmd(input in_item_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // drain: every owed report back, then let any walk in flight run out
  task automatic settle();
    start <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // write all three list lengths on consecutive cycles, enable held high
  task automatic write_lengths(input logic [LEN_W-1:0] hi_len, input logic [LEN_W-1:0] nm_len,
                               input logic [LEN_W-1:0] lo_len);
    logic [LEN_W-1:0] lens [NUM_LISTS];
    lens = '{hi_len, nm_len, lo_len};
    for (int l = 0; l < NUM_LISTS; l++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(l);
      cfg_wdata <= lens[l];
      @(posedge clk);
      shadow.set_length(l, lens[l]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [LEN_W-1:0] hl, nl, ll;
    int unsigned      pct_by_phase [3];
    shadow       = new();
    pct_by_phase = '{0, 53, 38};
    cycles       = 0;
    idle_pct     = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_HIGH_LEN;
    cfg_wdata    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // lengths are zero out of reset: nothing can fire
    send_cmd(make_cmd(OP_QUERY, '0, '0, '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(OP_EVAL, '0, '1, '0, '0, 1'b0, 1'b0));
    settle();
    // low list length above depth saturates at eight
    write_lengths(LEN_W'(LIST_DEPTH), LEN_W'(LIST_DEPTH), '1);

    // empty table evaluates to no match
    send_cmd(make_cmd(OP_EVAL, '0, '1, '0, '0, 1'b0, 1'b0));
    // edges of the table: first and last slot of the high list
    send_cmd(make_cmd(OP_WRITE, '1, '0, LIST_W'(0), IDX_W'(0), 1'b0, 1'b1));
    send_cmd(make_cmd(OP_WRITE, STATUS_W'(1), '0, LIST_W'(0), '1, 1'b1, 1'b1));
    // zero mask never fires even when enabled
    send_cmd(make_cmd(OP_WRITE, '0, '0, LIST_W'(1), IDX_W'(3), 1'b1, 1'b1));
    send_cmd(make_cmd(OP_WRITE, {1'b1, {(STATUS_W - 1){1'b0}}}, '0, LIST_W'(2), '1,
                      1'b0, 1'b1));
    // disabled entry stays silent
    send_cmd(make_cmd(OP_WRITE, STATUS_W'(3), '0, LIST_W'(2), IDX_W'(0), 1'b0, 1'b0));
    // write to the unused list id changes nothing
    send_cmd(make_cmd(OP_WRITE, STATUS_W'(15), '0, '1, IDX_W'(2), 1'b1, 1'b1));
    send_cmd(make_cmd(OP_SET, '1, '0, '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(OP_EVAL, '0, '1, '0, '0, 1'b0, 1'b0));
    // partial status: all-bits and any-bit entries both miss
    send_cmd(make_cmd(OP_CLEAR, {1'b1, {(STATUS_W - 2){1'b0}}, 1'b1}, '0, '0, '0,
                      1'b0, 1'b0));
    send_cmd(make_cmd(OP_EVAL, '0, '1, '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(OP_WRITE, STATUS_W'('h0f00), '0, LIST_W'(1), IDX_W'(5), 1'b1, 1'b1));
    send_cmd(make_cmd(OP_EVAL, '0, SEL_W'(2), '0, '0, 1'b0, 1'b0));
    // no list selected
    send_cmd(make_cmd(OP_EVAL, '0, '0, '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(OP_EVAL, '0, SEL_W'(5), '0, '0, 1'b0, 1'b0));
    // unused op code behaves as a query
    send_cmd(make_cmd(OP_LAST_CODE, '1, '1, '1, '1, 1'b1, 1'b1));
    send_cmd(make_cmd(OP_CLEAR, '1, '0, '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(OP_EVAL, '0, '1, '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(OP_SET, '0, '0, '0, '0, 1'b0, 1'b0));
    // one bit of an any-bit mask is enough
    send_cmd(make_cmd(OP_SET, STATUS_W'('h0100), '0, '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(OP_EVAL, '0, SEL_W'(2), '0, '0, 1'b0, 1'b0));
    send_cmd(make_cmd(OP_EVAL, '0, '1, '0, '0, 1'b0, 1'b0));

    // random phases: length settings include empty lists, full depth and
    // values past the depth; sender gaps vary per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin hl = LEN_W'(LIST_DEPTH); nl = LEN_W'(LIST_DEPTH); ll = LEN_W'(LIST_DEPTH); end
        1:       begin hl = '0; nl = '0; ll = '0; end
        2:       begin hl = '1; nl = LEN_W'(LIST_DEPTH); ll = LEN_W'(1); end
        3:       begin hl = LEN_W'(3); nl = LEN_W'(LIST_DEPTH + 1); ll = LEN_W'(LIST_DEPTH); end
        default: begin
          hl = LEN_W'($urandom);
          nl = LEN_W'($urandom);
          ll = LEN_W'($urandom);
        end
      endcase
      settle();
      write_lengths(hl, nl, ll);
      idle_pct = pct_by_phase[p % 3];
      repeat (PHASE_ITEMS) send_cmd(random_command());
    end

    settle();
    if (shadow.pending() != 0)
      $display("%0t: %0d expected results never arrived", $time, shadow.pending());
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("event_mask_matcher_tb passed");
    end else begin
      $display("event_mask_matcher_tb failed");
    end
    $finish;
  end

endmodule
